[sv/bmpw_pkg.sv]
// bmpw_pkg: shared types, constants and the header byte table of the 24-bit bmp writer
// used by bmpw_ctrl, bmpw_datapath and rgb_to_bmp24_writer_top; depends on nothing

package bmpw_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EMIT = 1'b1;

  localparam int HDR_BYTES  = 54;
  localparam int INFO_BYTES = 40;
  localparam int BPP        = 24;

  typedef enum logic [1:0] {
    ST_CALC_DIMS,
    ST_CALC_SIZES,
    ST_RUN,
    ST_FETCH
  } state_e;

  typedef struct packed {
    logic cfg_we;
    logic calc_dims;
    logic calc_sizes;
    logic load_px;
    logic emit;
    logic out_fill;
    logic out_take;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } stat_t;

  function automatic logic [7:0] header_byte(logic [5:0] pos, logic [31:0] size,
                                             logic [31:0] w, logic [31:0] h);
    logic [7:0] b;
    b = '0;
    unique case (pos)
      6'd0:    b = 8'h42;
      6'd1:    b = 8'h4D;
      6'd2:    b = size[7:0];
      6'd3:    b = size[15:8];
      6'd4:    b = size[23:16];
      6'd5:    b = size[31:24];
      6'd10:   b = 8'(HDR_BYTES);
      6'd14:   b = 8'(INFO_BYTES);
      6'd18:   b = w[7:0];
      6'd19:   b = w[15:8];
      6'd22:   b = h[7:0];
      6'd23:   b = h[15:8];
      6'd26:   b = 8'd1;
      6'd28:   b = 8'(BPP);
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

[sv/rgb_to_bmp24_writer_top.sv]
// rgb_to_bmp24_writer_top: 24-bit bmp file writer, top level
// depends on bmpw_pkg, bmpw_ctrl and bmpw_datapath
//
// usage: write image_width (index 0) and image_height (index 1) on the cfg
// channel, then send width*height load beats (req_type 0), top row first,
// left to right, each carrying red, green and blue. every emit beat
// (req_type 1) returns one out beat holding the next byte of the file:
// 54 header bytes, then pixel rows bottom row first in blue, green, red
// order, each row zero padded to a multiple of four bytes. last_byte marks
// the final byte, after which the block waits for a new image. an emit
// beat before the image is complete returns byte zero with not_ready set.
// an emit beat reads the registered frame store read port, then the fetch
// state fills the out register; no beat is taken in the fetch state.
// the out register frees the input side: a new beat is taken while the
// receiver takes the previous byte. after reset and after every cfg write
// the block computes the image geometry in its setup states before taking
// input beats. a stalled receiver holds one out beat and blocks further
// input until it is taken.

module rgb_to_bmp24_writer_top #(
  parameter int MAX_WIDTH  = bmpw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmpw_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [7:0]                      red_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      blue_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic                            last_byte_o,
  output logic                            not_ready_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bmpw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmpw_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bmpw_pkg::cmd_t  cmd;
  bmpw_pkg::stat_t stat;

  bmpw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .cfg_valid_i (cfg_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd)
  );

  bmpw_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .stat_o      (stat),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .not_ready_o (not_ready_o)
  );

  assign out_valid_o = stat.out_valid;

endmodule

[sv/bmpw_ctrl.sv]
// bmpw_ctrl: state machine sequencing setup, pixel loads and byte fetches
// depends on bmpw_pkg (state_e, cmd_t, stat_t, request codes)

module bmpw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           req_type_i,
  input  logic           cfg_valid_i,
  input  logic           out_ready_i,
  input  bmpw_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output logic           cfg_ready_o,
  output bmpw_pkg::cmd_t cmd_o
);

  bmpw_pkg::state_e state_q, state_d;
  logic             in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmpw_pkg::ST_CALC_DIMS;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b1;
    in_acc      = 1'b0;
    cmd_o.out_take = stat_i.out_valid && out_ready_i;
    unique case (state_q)
      bmpw_pkg::ST_CALC_DIMS: begin
        cmd_o.calc_dims = 1'b1;
        state_d = bmpw_pkg::ST_CALC_SIZES;
      end
      bmpw_pkg::ST_CALC_SIZES: begin
        cmd_o.calc_sizes = 1'b1;
        state_d = bmpw_pkg::ST_RUN;
      end
      bmpw_pkg::ST_RUN: begin
        in_ready_o = !stat_i.out_valid || out_ready_i;
        in_acc     = in_valid_i && in_ready_o;
        if (in_acc) begin
          if (req_type_i == bmpw_pkg::REQ_EMIT) begin
            cmd_o.emit = 1'b1;
            state_d = bmpw_pkg::ST_FETCH;
          end else begin
            cmd_o.load_px = 1'b1;
          end
        end
      end
      bmpw_pkg::ST_FETCH: begin
        cmd_o.out_fill = 1'b1;
        state_d = bmpw_pkg::ST_RUN;
      end
      default: begin
        state_d = bmpw_pkg::ST_CALC_DIMS;
      end
    endcase
    if (cfg_valid_i) begin
      cmd_o.cfg_we = 1'b1;
      state_d = bmpw_pkg::ST_CALC_DIMS;
    end
  end

endmodule

[sv/bmpw_datapath.sv]
// bmpw_datapath: config registers, frame store, file counters and output register
// depends on bmpw_pkg (cmd_t, stat_t, constants, header_byte)

module bmpw_datapath #(
  parameter int MAX_WIDTH  = bmpw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmpw_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bmpw_pkg::cmd_t                  cmd_i,
  input  logic [bmpw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmpw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]                      red_i,
  input  logic [7:0]                      green_i,
  input  logic [7:0]                      blue_i,
  output bmpw_pkg::stat_t                 stat_o,
  output logic [7:0]                      out_byte_o,
  output logic                            last_byte_o,
  output logic                            not_ready_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LCW    = $clog2(DEPTH + 1);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int W3W    = $clog2(3 * MAX_WIDTH + 1);
  localparam int RBMAX  = ((3 * MAX_WIDTH + 3) / 4) * 4;
  localparam int RBW    = $clog2(RBMAX + 1);
  localparam int SZW    = $clog2(bmpw_pkg::HDR_BYTES + RBMAX * MAX_HEIGHT + 1);

  logic [bmpw_pkg::CFG_DATA_W-1:0] width_q, height_q;

  logic [WW-1:0]  eff_w_q;
  logic [HW-1:0]  eff_h_q;
  logic [W3W-1:0] w3_q;
  logic [RBW-1:0] rb_q;
  logic [LCW-1:0] total_q;
  logic [SZW-1:0] size_q;
  logic [AW-1:0]  last_row_base_q;

  logic [LCW-1:0] load_cnt_q;
  logic [SZW-1:0] fpos_q;
  logic [RBW-1:0] row_byte_q;
  logic [1:0]     chan_q;
  logic [WW-1:0]  col_q;
  logic [AW-1:0]  row_base_q;

  logic [23:0]    mem_q [DEPTH];
  logic [23:0]    rd_q;

  logic           e_nr_q, e_hdr_q, e_pad_q, e_last_q;
  logic [1:0]     e_ch_q;
  logic [7:0]     e_hbyte_q;

  logic           out_valid_q;
  logic [7:0]     out_byte_q;
  logic           last_q, nr_q;

  logic [31:0]    wc, hc, rbc;
  logic           full, is_hdr, last, pad, row_end;
  logic [AW-1:0]  rd_addr;
  logic [7:0]     hbyte, px_byte;

  // clamp to the supported range
  always_comb begin
    wc = 32'(width_q);
    hc = 32'(height_q);
    if (wc == 32'd0) begin
      wc = 32'd1;
    end else if (wc > 32'(MAX_WIDTH)) begin
      wc = 32'(MAX_WIDTH);
    end
    if (hc == 32'd0) begin
      hc = 32'd1;
    end else if (hc > 32'(MAX_HEIGHT)) begin
      hc = 32'(MAX_HEIGHT);
    end
    rbc = (32'd3 * wc + 32'd3) & ~32'd3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bmpw_pkg::CFG_DATA_W'(1);
      height_q <= bmpw_pkg::CFG_DATA_W'(1);
    end else if (cmd_i.cfg_we) begin
      unique case (cfg_index_i)
        bmpw_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        bmpw_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // derived image geometry, two setup steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_dims) begin
      eff_w_q <= WW'(wc);
      eff_h_q <= HW'(hc);
      w3_q    <= W3W'(32'd3 * wc);
      rb_q    <= RBW'(rbc);
    end
    if (cmd_i.calc_sizes) begin
      total_q         <= LCW'(32'(eff_w_q) * 32'(eff_h_q));
      size_q          <= SZW'(32'(bmpw_pkg::HDR_BYTES) + 32'(rb_q) * 32'(eff_h_q));
      last_row_base_q <= AW'(32'(eff_h_q - HW'(1)) * 32'(eff_w_q));
    end
  end

  always_comb begin
    full    = (load_cnt_q == total_q);
    is_hdr  = (32'(fpos_q) < 32'(bmpw_pkg::HDR_BYTES));
    last    = ((33'(fpos_q) + 33'd1) == 33'(size_q));
    pad     = (32'(row_byte_q) >= 32'(w3_q));
    row_end = ((32'(row_byte_q) + 32'd1) >= 32'(rb_q));
    rd_addr = row_base_q + AW'(col_q);
    hbyte   = bmpw_pkg::header_byte(fpos_q[5:0], 32'(size_q), 32'(eff_w_q), 32'(eff_h_q));
  end

  // file counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      fpos_q     <= '0;
      row_byte_q <= '0;
      chan_q     <= '0;
      col_q      <= '0;
    end else if (cmd_i.cfg_we) begin
      load_cnt_q <= '0;
      fpos_q     <= '0;
      row_byte_q <= '0;
      chan_q     <= '0;
      col_q      <= '0;
    end else if (cmd_i.load_px) begin
      if (!full) begin
        load_cnt_q <= load_cnt_q + LCW'(1);
      end
    end else if (cmd_i.emit && full) begin
      if (last) begin
        load_cnt_q <= '0;
        fpos_q     <= '0;
        row_byte_q <= '0;
        chan_q     <= '0;
        col_q      <= '0;
      end else begin
        fpos_q <= fpos_q + SZW'(1);
        if (!is_hdr) begin
          if (row_end) begin
            row_byte_q <= '0;
            chan_q     <= '0;
            col_q      <= '0;
          end else begin
            row_byte_q <= row_byte_q + RBW'(1);
            chan_q     <= (chan_q == 2'd2) ? 2'd0 : chan_q + 2'd1;
            col_q      <= (chan_q == 2'd2) ? col_q + WW'(1) : col_q;
          end
        end
      end
    end
  end

  // bottom row first: row base steps back one row width
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_sizes) begin
      row_base_q <= AW'(32'(eff_h_q - HW'(1)) * 32'(eff_w_q));
    end else if (cmd_i.emit && full) begin
      if (last) begin
        row_base_q <= last_row_base_q;
      end else if (!is_hdr && row_end) begin
        row_base_q <= row_base_q - AW'(eff_w_q);
      end
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_px && !full) begin
      mem_q[load_cnt_q[AW-1:0]] <= {red_i, green_i, blue_i};
    end
    if (cmd_i.emit) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      e_nr_q    <= !full;
      e_hdr_q   <= is_hdr;
      e_pad_q   <= pad;
      e_last_q  <= full && last;
      e_ch_q    <= chan_q;
      e_hbyte_q <= hbyte;
    end
  end

  always_comb begin
    unique case (e_ch_q)
      2'd0:    px_byte = rd_q[7:0];
      2'd1:    px_byte = rd_q[15:8];
      default: px_byte = rd_q[23:16];
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_fill) begin
      out_valid_q <= 1'b1;
    end else if (cmd_i.out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_fill) begin
      nr_q   <= e_nr_q;
      last_q <= e_last_q;
      if (e_nr_q || (!e_hdr_q && e_pad_q)) begin
        out_byte_q <= '0;
      end else if (e_hdr_q) begin
        out_byte_q <= e_hbyte_q;
      end else begin
        out_byte_q <= px_byte;
      end
    end
  end

  assign stat_o.out_valid = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign last_byte_o      = last_q;
  assign not_ready_o      = nr_q;

endmodule

[bench/rgb_to_bmp24_writer_top_test.sv]
// rgb_to_bmp24_writer_top_test: self-checking bench for the 24-bit bmp file writer
// depends on bmpw_pkg and rgb_to_bmp24_writer_top; models the file stream beat by beat
// and compares every out beat against a queue of predicted file bytes

module rgb_to_bmp24_writer_top_test;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;
  localparam int unsigned UNLIMITED = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       req;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       typed;
    logic [7:0] data;
    logic       last;
    logic       nr;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       not_ready;
  } bmp_beat_t;

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic                            req_type_i  = bmpw_pkg::REQ_LOAD;
  logic [7:0]                      red_i       = 8'h00;
  logic [7:0]                      green_i     = 8'h00;
  logic [7:0]                      blue_i      = 8'h00;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [7:0]                      out_byte_o;
  logic                            last_byte_o;
  logic                            not_ready_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [bmpw_pkg::CFG_IDX_W-1:0]  cfg_index_i = bmpw_pkg::CFG_IMAGE_WIDTH;
  logic [bmpw_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // predicted image state
  logic [23:0] px_mem [0:65535];
  logic [8:0]  reg_w;
  logic [8:0]  reg_h;
  int unsigned n_loaded;
  int unsigned file_pos;
  int unsigned row_idx;
  int unsigned row_byte;
  int unsigned chan;

  bmp_beat_t   file_bytes_q [$];
  int unsigned fail_count    = 0;
  int unsigned beats_counted = 0;
  int unsigned images        = 0;
  int unsigned checked       = 0;
  int unsigned nr_seen       = 0;
  int unsigned stall_left    = 0;
  bit          sender_gaps   = 1'b1;
  bit          receiver_gaps = 1'b1;

  // 1x1 image after reset, file size 58
  stim_row_t dir_rows [24] = '{
    '{bmpw_pkg::REQ_EMIT, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00,  1'b0, 1'b1},
    '{bmpw_pkg::REQ_LOAD, 8'hFF, 8'h00, 8'hFF, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_LOAD, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'hFF, 8'hFF, 8'hFF, 1'b1, SIG_B,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h00, 8'h00, 8'h00, 1'b1, SIG_M,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h12, 8'h34, 8'h56, 1'b1, 8'd58,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h5A, 8'hA5, 8'h3C, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h5A, 8'hA5, 8'h3C, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h5A, 8'hA5, 8'h3C, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h5A, 8'hA5, 8'h3C, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h5A, 8'hA5, 8'h3C, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h5A, 8'hA5, 8'h3C, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h5A, 8'hA5, 8'h3C, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h00, 8'h00, 8'h00, 1'b1, 8'd54,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'hC3, 8'h3C, 8'h81, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'hC3, 8'h3C, 8'h81, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'hC3, 8'h3C, 8'h81, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h00, 8'h00, 8'h00, 1'b1, 8'd40,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h7E, 8'hE7, 8'h18, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h7E, 8'hE7, 8'h18, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h7E, 8'hE7, 8'h18, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h00, 8'h00, 8'h00, 1'b1, 8'd1,   1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h7E, 8'hE7, 8'h18, 1'b0, 8'h00,  1'b0, 1'b0},
    '{bmpw_pkg::REQ_EMIT, 8'h7E, 8'hE7, 8'h18, 1'b0, 8'h00,  1'b0, 1'b0}
  };

  rgb_to_bmp24_writer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .not_ready_o (not_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting on handshakes");
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned eff_dim(input logic [8:0] v, input int unsigned max_v);
    if (v == 9'd0) return 1;
    if (32'(v) > max_v) return max_v;
    return 32'(v);
  endfunction

  function automatic int unsigned img_w();
    return eff_dim(reg_w, bmpw_pkg::DEF_MAX_WIDTH);
  endfunction

  function automatic int unsigned img_h();
    return eff_dim(reg_h, bmpw_pkg::DEF_MAX_HEIGHT);
  endfunction

  // row length in bytes, padded to a multiple of four
  function automatic int unsigned row_len();
    return (3 * img_w() + 3) & ~32'd3;
  endfunction

  function automatic int unsigned file_len();
    return bmpw_pkg::HDR_BYTES + row_len() * img_h();
  endfunction

  function automatic void restart_image();
    n_loaded = 0;
    file_pos = 0;
    row_idx  = img_h() - 1;
    row_byte = 0;
    chan     = 0;
  endfunction

  function automatic logic [7:0] hdr_byte(input int unsigned pos);
    logic [31:0] size;
    logic [31:0] w;
    logic [31:0] h;
    w    = img_w();
    h    = img_h();
    size = file_len();
    case (pos)
      0:       return SIG_B;
      1:       return SIG_M;
      2:       return size[7:0];
      3:       return size[15:8];
      4:       return size[23:16];
      5:       return size[31:24];
      10:      return 8'(bmpw_pkg::HDR_BYTES);
      14:      return 8'(bmpw_pkg::INFO_BYTES);
      18:      return w[7:0];
      19:      return w[15:8];
      22:      return h[7:0];
      23:      return h[15:8];
      26:      return 8'd1;
      28:      return 8'(bmpw_pkg::BPP);
      default: return 8'd0;
    endcase
  endfunction

  function automatic bit predict_bmp_beat(input stim_row_t row, output bmp_beat_t e);
    int unsigned w;
    int unsigned n_px;
    logic [23:0] px;
    w    = img_w();
    n_px = w * img_h();
    e    = '{8'h00, 1'b0, 1'b0};
    if (row.req == bmpw_pkg::REQ_LOAD) begin
      if (n_loaded < n_px) begin
        px_mem[16'(n_loaded)] = {row.r, row.g, row.b};
        n_loaded++;
      end
      return 1'b0;
    end
    if (n_loaded < n_px) begin
      e.not_ready = 1'b1;
      return 1'b1;
    end
    if (file_pos < bmpw_pkg::HDR_BYTES) begin
      e.data = hdr_byte(file_pos);
    end else begin
      if (row_byte < 3 * w) begin
        px     = px_mem[16'(row_idx * w + row_byte / 3)];
        e.data = px[8*chan +: 8];
      end
      row_byte++;
      chan = (chan >= 2) ? 0 : chan + 1;
      if (row_byte >= row_len()) begin
        row_byte = 0;
        chan     = 0;
        row_idx--;
      end
    end
    if (file_pos + 1 >= file_len()) begin
      e.last = 1'b1;
      restart_image();
    end else begin
      file_pos++;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t rand_row(input logic req);
    stim_row_t row;
    row     = '0;
    row.req = req;
    row.r   = 8'($urandom);
    row.g   = 8'($urandom);
    row.b   = 8'($urandom);
    return row;
  endfunction

  task automatic send_beat(input stim_row_t row);
    bmp_beat_t e;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= row.req;
    red_i      <= row.r;
    green_i    <= row.g;
    blue_i     <= row.b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_counted++;
    if (predict_bmp_beat(row, e)) begin
      if (row.typed) e = '{row.data, row.last, row.nr};
      file_bytes_q = {file_bytes_q, e};
    end
  endtask

  // hold the sender until every predicted beat is out and the block has settled
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (file_bytes_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bmpw_pkg::CFG_IDX_W-1:0] idx, input logic [8:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == bmpw_pkg::CFG_IMAGE_WIDTH) reg_w = val;
    else reg_h = val;
    restart_image();
    @(posedge clk_i);
  endtask

  task automatic run_image(input logic [8:0] w_reg, input logic [8:0] h_reg,
                           input int unsigned load_cut, input int unsigned emit_cut);
    int unsigned n_px;
    int unsigned n_bytes;
    int unsigned i;
    drain_results();
    write_reg(bmpw_pkg::CFG_IMAGE_WIDTH, w_reg);
    write_reg(bmpw_pkg::CFG_IMAGE_HEIGHT, h_reg);
    images++;
    n_px    = img_w() * img_h();
    n_bytes = file_len();
    for (i = 0; i < n_px && i < load_cut; i++) begin
      if ($urandom_range(0, 15) == 0) send_beat(rand_row(bmpw_pkg::REQ_EMIT));
      send_beat(rand_row(bmpw_pkg::REQ_LOAD));
    end
    for (i = 0; i < n_bytes && i < emit_cut; i++) begin
      if ($urandom_range(0, 19) == 0) send_beat(rand_row(bmpw_pkg::REQ_LOAD));
      send_beat(rand_row(bmpw_pkg::REQ_EMIT));
    end
    // emit right after the last byte finds an empty image
    if (emit_cut > n_bytes && $urandom_range(0, 2) == 0) begin
      send_beat(rand_row(bmpw_pkg::REQ_EMIT));
    end
  endtask

  always @(posedge clk_i) begin
    bmp_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (file_bytes_q.size() == 0) begin
        $error("out beat with nothing pending: out_byte %02h", out_byte_o);
        fail_count++;
      end else begin
        want = file_bytes_q.pop_front();
        checked++;
        if (not_ready_o === 1'b1) nr_seen++;
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_byte_o);
          fail_count++;
        end
        if (last_byte_o !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, last_byte_o);
          fail_count++;
        end
        if (not_ready_o !== want.not_ready) begin
          $error("not_ready: expected %0b, actual %0b", want.not_ready, not_ready_o);
          fail_count++;
        end
      end
    end
    if (!rst_ni || !receiver_gaps) begin
      stall_left  = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left  = $urandom_range(1, 19) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    logic [8:0]  w;
    logic [8:0]  h;
    int unsigned n_px;
    int unsigned guard;
    int unsigned i;
    reg_w = 9'd1;
    reg_h = 9'd1;
    restart_image();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) send_beat(dir_rows[k]);

    // clamped and maximal geometries
    run_image(9'd0, 9'd0, UNLIMITED, UNLIMITED);
    run_image(9'd511, 9'd1, UNLIMITED, bmpw_pkg::HDR_BYTES + $urandom_range(60, 160));
    run_image(9'd1, 9'd300, UNLIMITED, bmpw_pkg::HDR_BYTES + $urandom_range(30, 120));
    run_image(9'd256, 9'd256, $urandom_range(20, 40), 3);

    while (beats_counted < 1250) begin
      sender_gaps   = ($urandom_range(0, 3) != 0);
      receiver_gaps = ($urandom_range(0, 3) != 0);
      w    = 9'($urandom_range(1, 12));
      h    = 9'($urandom_range(1, 5));
      n_px = 32'(w) * 32'(h);
      case ($urandom_range(0, 7))
        0: run_image(w, h, $urandom_range(0, n_px - 1), 2);
        1: run_image(w, h, UNLIMITED, $urandom_range(1, bmpw_pkg::HDR_BYTES + 12));
        default: run_image(w, h, UNLIMITED, UNLIMITED);
      endcase
    end

    // closing stretch with both sides running flat out
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    for (i = 0; i < 3; i++) begin
      run_image(9'($urandom_range(1, 9)), 9'($urandom_range(1, 4)), UNLIMITED, UNLIMITED);
    end

    in_valid_i <= 1'b0;
    guard = 0;
    while (file_bytes_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (file_bytes_q.size() != 0) begin
      $error("%0d predicted out beats never arrived", file_bytes_q.size());
      fail_count++;
    end
    $display("%0d accepted beats over %0d image setups, %0d out beats checked (%0d not ready)",
             beats_counted, images, checked, nr_seen);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
